### design/emu_pkg.sv
// shared types and constants for the elgamal modular exponentiation unit
// no dependencies; imported by emu_modmul and elgamal_modexp_unit
package emu_pkg;

   // width of every item field on the stream ports
   localparam int FIELD_W = 16;

   // configuration register indexes
   localparam logic [1:0] CSR_PRIME     = 2'd0;
   localparam logic [1:0] CSR_GENERATOR = 2'd1;
   localparam logic [1:0] CSR_PRIVATE   = 2'd2;

   // operation codes carried in tuser
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   // sequencer states
   typedef enum logic [9:0] {
      ST_IDLE      = 10'b0000000001,
      ST_XRED_GO   = 10'b0000000010,
      ST_XRED_WAIT = 10'b0000000100,
      ST_SQ_GO     = 10'b0000001000,
      ST_SQ_WAIT   = 10'b0000010000,
      ST_MUL_GO    = 10'b0000100000,
      ST_MUL_WAIT  = 10'b0001000000,
      ST_FIN_GO    = 10'b0010000000,
      ST_FIN_WAIT  = 10'b0100000000,
      ST_OUT       = 10'b1000000000
   } state_type;

   // which exponentiation the shared square-and-multiply loop is running
   typedef enum logic [1:0] {
      PH_PUBKEY  = 2'd0,
      PH_CIPHER  = 2'd1,
      PH_DECRYPT = 2'd2
   } phase_type;

endpackage

### design/elgamal_modexp_unit.sv
// elgamal encrypt / decrypt over a configured prime, square-and-multiply sequencer
// on two emu_modmul units; uses emu_pkg
//
// each modular multiply walks the multiplier bits; one exponentiation runs a square
//   for every exponent bit and a multiply for every one bit.
// encrypt: public key power, then a and b powers in parallel on both units, then one
//   multiply. decrypt: key reduction, one power, one multiply; items with no result
//   are dropped at acceptance.
// one item at a time; a result waits in the output register while the next item runs.
// reset (synchronous) returns to idle, empties the output and restores 593, 123, 8.
module elgamal_modexp_unit
   import emu_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   // input items
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [63:0]      req_tdata,   // message, nonce, cipher_first, cipher_second
   input  logic             req_tuser,   // operation
   // result items
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [31:0]      rsp_tdata,   // first_value, second_value
   // configuration writes
   input  logic             csr_we,
   input  logic [1:0]       csr_addr,
   input  logic [WIDTH-1:0] csr_wdata
);

   localparam int CW = $clog2(WIDTH);

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic             op_ff, op_in;
   logic [WIDTH-1:0] p_ff, p_in;
   logic [WIDTH-1:0] g_ff, g_in;
   logic [WIDTH-1:0] x_ff, x_in;
   logic [WIDTH-1:0] tail_ff, tail_in;
   logic [WIDTH-1:0] nonce_ff, nonce_in;
   logic [WIDTH-1:0] r0_ff, r0_in;
   logic [WIDTH-1:0] r1_ff, r1_in;
   logic [WIDTH-1:0] base0_ff, base0_in;
   logic [WIDTH-1:0] base1_ff, base1_in;
   logic [WIDTH-1:0] exp_ff, exp_in;
   logic [CW-1:0]    bitcnt_ff, bitcnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_data_ff, rsp_data_in;

   logic             step_end;
   logic             start_a, start_b;
   logic             done_a, done_b;
   logic [WIDTH-1:0] prod_a, prod_b;
   logic [WIDTH-1:0] u_a, v_a, m_a, v_b;
   logic [WIDTH-1:0] in_msg, in_nonce, in_ca, in_cb;
   logic [WIDTH-1:0] p_less_one;

   // item fields brought to the datapath width
   assign in_msg     = WIDTH'(req_tdata[15:0]);
   assign in_nonce   = WIDTH'(req_tdata[31:16]);
   assign in_ca      = WIDTH'(req_tdata[47:32]);
   assign in_cb      = WIDTH'(req_tdata[63:48]);
   assign p_less_one = p_ff - WIDTH'(1);

   // configuration registers
   always_comb begin
      p_in = p_ff;
      g_in = g_ff;
      x_in = x_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_PRIME:     p_in = csr_wdata;
            CSR_GENERATOR: g_in = csr_wdata;
            CSR_PRIVATE:   x_in = csr_wdata;
            default:       ;
         endcase
      end
   end

   // operand selection for the two multipliers, latched by them on start
   always_comb begin
      unique case (state_ff)
         ST_XRED_GO: begin
            u_a = WIDTH'(1);
            v_a = x_ff;
            m_a = p_less_one;
         end
         ST_MUL_GO: begin
            u_a = r0_ff;
            v_a = base0_ff;
            m_a = p_ff;
         end
         ST_FIN_GO: begin
            u_a = (op_ff == OP_DECRYPT) ? r0_ff : r1_ff;
            v_a = tail_ff;
            m_a = p_ff;
         end
         default: begin
            u_a = r0_ff;
            v_a = r0_ff;
            m_a = p_ff;
         end
      endcase
      v_b = (state_ff == ST_MUL_GO) ? base1_ff : r1_ff;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      op_in        = op_ff;
      tail_in      = tail_ff;
      nonce_in     = nonce_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      base0_in     = base0_ff;
      base1_in     = base1_ff;
      exp_in       = exp_ff;
      bitcnt_in    = bitcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      start_a      = 1'b0;
      start_b      = 1'b0;
      step_end     = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser;
               tail_in   = (req_tuser == OP_DECRYPT) ? in_cb : in_msg;
               nonce_in  = in_nonce;
               base0_in  = (req_tuser == OP_DECRYPT) ? in_ca : g_ff;
               base1_in  = g_ff;
               r0_in     = WIDTH'(1);
               r1_in     = WIDTH'(1);
               exp_in    = x_ff;
               phase_in  = PH_PUBKEY;
               bitcnt_in = CW'(WIDTH - 1);
               // degenerate modulus or zero cipher part: item is dropped
               priority if (p_ff < WIDTH'(2)) begin
                  state_in = ST_IDLE;
               end else if (req_tuser == OP_ENCRYPT) begin
                  state_in = ST_SQ_GO;
               end else if (in_ca == '0 || in_cb == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_XRED_GO;
               end
            end
         end
         ST_XRED_GO: begin
            start_a  = 1'b1;
            state_in = ST_XRED_WAIT;
         end
         ST_XRED_WAIT: begin
            // decrypt exponent (p-1) - (x mod (p-1))
            if (done_a) begin
               exp_in   = p_less_one - prod_a;
               phase_in = PH_DECRYPT;
               state_in = ST_SQ_GO;
            end
         end
         ST_SQ_GO: begin
            start_a  = 1'b1;
            start_b  = 1'b1;
            state_in = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (done_a) begin
               r0_in = prod_a;
               r1_in = prod_b;
               if (exp_ff[WIDTH-1]) begin
                  state_in = ST_MUL_GO;
               end else begin
                  step_end = 1'b1;
               end
            end
         end
         ST_MUL_GO: begin
            start_a  = 1'b1;
            start_b  = 1'b1;
            state_in = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (done_a) begin
               r0_in    = prod_a;
               r1_in    = prod_b;
               step_end = 1'b1;
            end
         end
         ST_FIN_GO: begin
            start_a  = 1'b1;
            state_in = ST_FIN_WAIT;
         end
         ST_FIN_WAIT: begin
            // r0 / r1 now hold first and second value
            if (done_a) begin
               r0_in    = (op_ff == OP_DECRYPT) ? prod_a : r0_ff;
               r1_in    = (op_ff == OP_DECRYPT) ? '0 : prod_a;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {FIELD_W'(r1_ff), FIELD_W'(r0_ff)};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // end of one exponent bit: next bit, next phase or the final multiply
      if (step_end) begin
         exp_in = {exp_ff[WIDTH-2:0], 1'b0};
         if (bitcnt_ff == '0) begin
            unique case (phase_ff)
               PH_PUBKEY: begin
                  // public key y is done; run g^k and y^k side by side
                  base1_in  = r0_in;
                  r0_in     = WIDTH'(1);
                  r1_in     = WIDTH'(1);
                  exp_in    = nonce_ff;
                  phase_in  = PH_CIPHER;
                  bitcnt_in = CW'(WIDTH - 1);
                  state_in  = ST_SQ_GO;
               end
               default: begin
                  state_in = ST_FIN_GO;
               end
            endcase
         end else begin
            bitcnt_in = bitcnt_ff - CW'(1);
            state_in  = ST_SQ_GO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_PUBKEY;
         bitcnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         p_ff         <= WIDTH'(593);
         g_ff         <= WIDTH'(123);
         x_ff         <= WIDTH'(8);
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         bitcnt_ff    <= bitcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         p_ff         <= p_in;
         g_ff         <= g_in;
         x_ff         <= x_in;
      end
      op_ff       <= op_in;
      tail_ff     <= tail_in;
      nonce_ff    <= nonce_in;
      r0_ff       <= r0_in;
      r1_ff       <= r1_in;
      base0_ff    <= base0_in;
      base1_ff    <= base1_in;
      exp_ff      <= exp_in;
      rsp_data_ff <= rsp_data_in;
   end

   // multiplier for r0 (and key reduction, final product)
   emu_modmul #(.WIDTH(WIDTH)) u_mul_a (
      .clock   (clock),
      .reset   (reset),
      .start   (start_a),
      .op_u    (u_a),
      .op_v    (v_a),
      .modulus (m_a),
      .done    (done_a),
      .product (prod_a)
   );

   // multiplier for r1 (y^k during encrypt)
   emu_modmul #(.WIDTH(WIDTH)) u_mul_b (
      .clock   (clock),
      .reset   (reset),
      .start   (start_b),
      .op_u    (r1_ff),
      .op_v    (v_b),
      .modulus (p_ff),
      .done    (done_b),
      .product (prod_b)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a product only arrives while the sequencer waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      done_a |-> (state_ff == ST_XRED_WAIT || state_ff == ST_SQ_WAIT ||
                  state_ff == ST_MUL_WAIT || state_ff == ST_FIN_WAIT))
      else $error("multiplier result outside a wait state");

   // both units run in lockstep through the power loop
   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      (done_a && (state_ff == ST_SQ_WAIT || state_ff == ST_MUL_WAIT)) |-> done_b)
      else $error("multipliers out of step");

   // a finished item lands in the output register and frees the input
   a_result_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready)) |=>
         (rsp_tvalid && req_tready))
      else $error("result not delivered to output register");

endmodule

### design/emu_modmul.sv
// bit-serial modular multiplier: one multiplier bit per cycle, msb first
// product = u * v mod m, needs u < m (v may be any value); uses emu_pkg
module emu_modmul
   import emu_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] op_u,
   input  logic [WIDTH-1:0] op_v,
   input  logic [WIDTH-1:0] modulus,
   output logic             done,
   output logic [WIDTH-1:0] product
);

   localparam int CW = $clog2(WIDTH);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] u_ff, u_in;
   logic [WIDTH-1:0] v_ff, v_in;
   logic [WIDTH-1:0] m_ff, m_in;

   logic [WIDTH+1:0] sum;
   logic [WIDTH+1:0] m_one;
   logic [WIDTH+1:0] m_two;
   logic [WIDTH-1:0] acc_step;

   // double-and-add step, sum stays below three times the modulus
   always_comb begin
      m_one = {2'b00, m_ff};
      m_two = {1'b0, m_ff, 1'b0};
      sum   = {1'b0, acc_ff, 1'b0} + (v_ff[WIDTH-1] ? {2'b00, u_ff} : '0);
      priority if (sum >= m_two) begin
         acc_step = WIDTH'(sum - m_two);
      end else if (sum >= m_one) begin
         acc_step = WIDTH'(sum - m_one);
      end else begin
         acc_step = WIDTH'(sum);
      end
   end

   // load on start, then walk the multiplier bits
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      u_in    = u_ff;
      v_in    = v_ff;
      m_in    = m_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(WIDTH - 1);
         acc_in  = '0;
         u_in    = op_u;
         v_in    = op_v;
         m_in    = modulus;
      end else if (busy_ff) begin
         acc_in = acc_step;
         v_in   = {v_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      u_ff   <= u_in;
      v_ff   <= v_in;
      m_ff   <= m_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

   // a new product is only requested while the unit is free
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("modmul started while busy");

   // the last bit step ends the run and flags the product
   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == '0) |=> (done_ff && !busy_ff))
      else $error("modmul did not finish after its last bit");

   // done only follows a busy run
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("modmul done without a run");

endmodule

### verif/tb_elgamal_modexp_unit.sv
// testbench for elgamal_modexp_unit: directed and random encrypt / decrypt items over
// several prime, generator and key settings, each result checked against a local predictor
// depends on emu_pkg and the elgamal_modexp_unit rtl
module tb_elgamal_modexp_unit
   import emu_pkg::*;
();

   localparam int SETTLE_CYCLES = 1300;     // a little over the worst item latency
   localparam int DRAIN_LIMIT   = 20000;

   // one result item, first field in the low bits
   typedef struct packed {
      logic [15:0] second;
      logic [15:0] first;
   } cipher_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // message, nonce, cipher_first, cipher_second
   logic        req_tuser;   // operation
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // first_value, second_value
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [15:0] csr_wdata;

   // register copies used by the predictor
   logic [15:0] cur_prime;
   logic [15:0] cur_gen;
   logic [15:0] cur_key;

   cipher_result_type pending_results[$];
   bit quiet;
   int rsp_hold;
   int n_errors;
   int n_checked;
   int n_encrypt;
   int n_decrypt;
   int n_settings;

   elgamal_modexp_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // modular arithmetic on 16-bit operands
   function automatic logic [15:0] mod_mul(input logic [15:0] u, input logic [15:0] v,
                                          input logic [15:0] m);
      logic [31:0] prod;
      prod = {16'd0, u} * {16'd0, v};
      return 16'(prod % {16'd0, m});
   endfunction

   function automatic logic [15:0] mod_pow(input logic [15:0] base, input logic [15:0] ex,
                                          input logic [15:0] m);
      logic [15:0] acc;
      acc = 16'd1 % m;
      for (int i = 15; i >= 0; i--) begin
         acc = mod_mul(acc, acc, m);
         if (ex[i])
            acc = mod_mul(acc, base, m);
      end
      return acc;
   endfunction

   // expected result of one item under the current registers; 0 when none comes out
   function automatic bit cipher_predict(input logic op, input logic [15:0] msg,
                                         input logic [15:0] nonce, input logic [15:0] ca,
                                         input logic [15:0] cb,
                                         output cipher_result_type res);
      logic [15:0] p;
      logic [15:0] g;
      logic [15:0] y;
      logic [15:0] e;
      p = cur_prime;
      res = '0;
      if (p < 2)
         return 1'b0;
      if (op == OP_ENCRYPT) begin
         g = cur_gen % p;
         y = mod_pow(g, cur_key, p);
         res.first = mod_pow(g, nonce, p);
         res.second = mod_mul(mod_pow(y, nonce, p), msg % p, p);
      end else begin
         if (ca == 0 || cb == 0)
            return 1'b0;
         e = (p - 16'd1) - (cur_key % (p - 16'd1));
         res.first = mod_mul(cb % p, mod_pow(ca % p, e, p), p);
         res.second = 16'd0;
      end
      return 1'b1;
   endfunction

   // idle length: mostly none or short, a few long
   function automatic int idle_gap();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                  : $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each accepted result with the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected result, expected none, got first %0d second %0d",
                     $time, rsp_tdata[15:0], rsp_tdata[31:16]);
         end else begin
            n_checked++;
            if (rsp_tdata[15:0] !== pending_results[0].first) begin
               n_errors++;
               $display("%0t: first_value mismatch, expected %0d, got %0d",
                        $time, pending_results[0].first, rsp_tdata[15:0]);
            end
            if (rsp_tdata[31:16] !== pending_results[0].second) begin
               n_errors++;
               $display("%0t: second_value mismatch, expected %0d, got %0d",
                        $time, pending_results[0].second, rsp_tdata[31:16]);
            end
            void'(pending_results.pop_front());
         end
      end
   end

   // send one item and record what it should produce
   task automatic send_item(input logic op, input logic [15:0] msg, input logic [15:0] nonce,
                            input logic [15:0] ca, input logic [15:0] cb);
      int gap;
      cipher_result_type res;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {cb, ca, nonce, msg};
      do @(posedge clock); while (!req_tready);
      if (cipher_predict(op, msg, nonce, ca, cb, res))
         pending_results.push_back(res);
      if (op == OP_ENCRYPT)
         n_encrypt++;
      else
         n_decrypt++;
   endtask

   // wait for every expected result, then for the unit to go quiet
   task automatic settle_results();
      int waited;
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_results.size() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results.size() > 0) begin
         n_errors += pending_results.size();
         $display("%0t: %0d expected results never arrived, got none",
                  $time, pending_results.size());
         pending_results.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PRIME:     cur_prime = val;
         CSR_GENERATOR: cur_gen = val;
         CSR_PRIVATE:   cur_key = val;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [15:0] p, input logic [15:0] g,
                             input logic [15:0] x);
      write_csr(CSR_PRIME, p);
      write_csr(CSR_GENERATOR, g);
      write_csr(CSR_PRIVATE, x);
      n_settings++;
   endtask

   // decrypt a message encrypted locally, used for round trips
   task automatic send_round_trip(input logic [15:0] msg, input logic [15:0] nonce);
      cipher_result_type enc;
      void'(cipher_predict(OP_ENCRYPT, msg, nonce, 16'd0, 16'd0, enc));
      send_item(OP_DECRYPT, 16'($urandom), 16'($urandom), enc.first, enc.second);
   endtask

   // field extremes, both operations and zero cipher parts at the reset registers
   task automatic test_reset_registers();
      send_item(OP_ENCRYPT, 16'd0, 16'd1, 16'd0, 16'd0);
      send_item(OP_ENCRYPT, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send_item(OP_ENCRYPT, 16'd5, 16'd0, 16'd0, 16'd0);
      send_item(OP_ENCRYPT, 16'd592, 16'd591, 16'd0, 16'd0);
      send_item(OP_ENCRYPT, 16'd593, 16'd100, 16'd0, 16'd0);
      send_item(OP_DECRYPT, 16'd0, 16'd0, 16'd0, 16'd5);
      send_item(OP_DECRYPT, 16'd0, 16'd0, 16'd5, 16'd0);
      send_item(OP_DECRYPT, 16'hffff, 16'hffff, 16'd0, 16'd0);
      send_item(OP_DECRYPT, 16'd0, 16'd0, 16'hffff, 16'hffff);
      send_item(OP_DECRYPT, 16'd0, 16'd0, 16'd593, 16'd1);
      send_item(OP_DECRYPT, 16'd0, 16'd0, 16'd1, 16'd1);
      send_round_trip(16'd321, 16'd77);
      settle_results();
   endtask

   // generator above p, zero key, non-prime top modulus and a modulus below two
   task automatic test_register_extremes();
      set_config(16'd593, 16'd600, 16'd0);
      send_item(OP_ENCRYPT, 16'd42, 16'd9, 16'd0, 16'd0);
      send_item(OP_DECRYPT, 16'd0, 16'd0, 16'd17, 16'd42);
      settle_results();
      set_config(16'hffff, 16'hffff, 16'hffff);
      send_item(OP_ENCRYPT, 16'hfffe, 16'h8001, 16'd0, 16'd0);
      send_item(OP_DECRYPT, 16'd0, 16'd0, 16'hfffe, 16'h1234);
      settle_results();
      set_config(16'd1, 16'd1, 16'd1);
      send_item(OP_ENCRYPT, 16'd1, 16'd1, 16'd0, 16'd0);
      send_item(OP_DECRYPT, 16'd0, 16'd0, 16'd1, 16'd1);
      settle_results();
      set_config(16'd0, 16'd0, 16'd0);
      send_item(OP_ENCRYPT, 16'd7, 16'd3, 16'd0, 16'd0);
      send_item(OP_DECRYPT, 16'd0, 16'd0, 16'd7, 16'd3);
      settle_results();
   endtask

   // random items, mostly encrypts and decrypts of real cipher pairs
   task automatic run_random(input int count);
      int r;
      logic [15:0] msg;
      logic [15:0] nonce;
      for (int i = 0; i < count; i++) begin
         quiet = ((i / 40) % 4 == 3);
         r = $urandom_range(0, 99);
         msg = ($urandom_range(0, 1) == 0 && cur_prime > 0)
               ? 16'($urandom_range(0, cur_prime - 1))
               : 16'($urandom_range(0, 65535));
         nonce = (cur_prime > 3 && $urandom_range(0, 9) < 7)
                 ? 16'($urandom_range(1, cur_prime - 2))
                 : 16'($urandom_range(0, 65535));
         if (r < 40)
            send_item(OP_ENCRYPT, msg, nonce, 16'($urandom), 16'($urandom));
         else if (r < 80)
            send_round_trip(msg, nonce);
         else if (r < 92)
            send_item(OP_DECRYPT, 16'($urandom), 16'($urandom),
                      ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom),
                      ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom));
         else
            send_item(OP_ENCRYPT, ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hffff,
                      ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hffff, 16'd0, 16'd0);
      end
      quiet = 1'b0;
      settle_results();
   endtask

   // random items over a range of register settings
   task automatic test_random_settings();
      logic [15:0] p;
      set_config(16'd593, 16'd123, 16'd8);
      run_random(110);
      set_config(16'd65521, 16'd17, 16'($urandom_range(1, 65519)));
      run_random(110);
      set_config(16'hffff, 16'hffff, 16'hffff);
      run_random(45);
      set_config(16'd3, 16'd2, 16'd1);
      run_random(45);
      set_config(16'd2, 16'd1, 16'd0);
      run_random(30);
      for (int s = 0; s < 4; s++) begin
         case ($urandom_range(0, 3))
            0: p = 16'd257;
            1: p = 16'd7919;
            2: p = 16'd32749;
            default: p = 16'd65519;
         endcase
         set_config(p, 16'($urandom_range(1, p - 1)), 16'($urandom_range(1, p - 2)));
         run_random(25);
      end
      set_config(16'd1, 16'($urandom), 16'($urandom));
      run_random(25);
      set_config(16'd0, 16'($urandom), 16'($urandom));
      run_random(25);
   endtask

   initial begin
      clock = 1'b0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= OP_ENCRYPT;
      req_tdata <= '0;
      rsp_tready <= 1'b0;
      csr_we <= 1'b0;
      csr_addr <= CSR_PRIME;
      csr_wdata <= '0;
      cur_prime = 16'd593;
      cur_gen = 16'd123;
      cur_key = 16'd8;
      quiet = 1'b0;
      rsp_hold = 0;
      n_errors = 0;
      n_checked = 0;
      n_encrypt = 0;
      n_decrypt = 0;
      n_settings = 1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_registers();
      test_register_extremes();
      test_random_settings();

      $display("ran %0d encrypt and %0d decrypt items across %0d register settings",
               n_encrypt, n_decrypt, n_settings);
      $display("compared %0d results, %0d mismatches", n_checked, n_errors);
      if (n_errors == 0)
         $display("elgamal_modexp_unit test passed");
      else
         $display("elgamal_modexp_unit test failed");
      $finish;
   end

   // overall time limit
   initial begin
      #32000000;
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("elgamal_modexp_unit test failed");
      $finish;
   end

endmodule
